>>> sv/hcr_pkg.sv
package hcr_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int SMOOTH_RADIUS_DEF = 3;

    // field widths
    localparam int CFG_DATA_W = 43;
    localparam int CFG_IDX_W  = 3;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 10;
    localparam int PROD_LINES = 6;
    localparam int ENTRY_W    = 63;
    localparam int WIN_TAPS   = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_WEIGHT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ENABLE    = 3'd4;

    // configuration reset values
    localparam logic [10:0] IMAGE_WIDTH_RST      = 11'd640;
    localparam logic [10:0] IMAGE_HEIGHT_RST     = 11'd480;
    localparam logic [6:0]  K_WEIGHT_RST         = 7'd10;
    localparam logic [42:0] CORNER_THRESHOLD_RST = 43'd1000000;
    localparam logic        SMOOTH_ENABLE_RST    = 1'b1;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [6:0]  k_weight;
        logic [42:0] corner_threshold;
        logic        smooth_enable;
    } hcr_cfg_t;

    // one queued pixel: grey value and its raster position
    typedef struct packed {
        logic [7:0]       grey;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } hcr_item_t;

    // three gradient products, widened to signed
    typedef struct packed {
        logic signed [21:0] a;
        logic signed [21:0] b;
        logic signed [21:0] c;
    } hcr_trip_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_WIN,
        B_PROD,
        B_VACC,
        B_VFLR,
        B_HACC,
        B_HFLR,
        B_MUL,
        B_KMUL,
        B_RESP
    } hcr_state_t;

    // q8 gaussian taps
    function automatic logic [6:0] gauss_tap(input logic [2:0] idx);
        logic [6:0] t;
        case (idx)
            3'd0:    t = 7'd1;
            3'd1:    t = 7'd14;
            3'd2:    t = 7'd62;
            3'd3:    t = 7'd102;
            3'd4:    t = 7'd62;
            3'd5:    t = 7'd14;
            3'd6:    t = 7'd1;
            default: t = 7'd0;
        endcase
        return t;
    endfunction

    function automatic hcr_trip_t unpack_trip(input logic [ENTRY_W-1:0] e);
        hcr_trip_t t;
        t.a = {1'b0, e[20:0]};
        t.b = {1'b0, e[41:21]};
        t.c = {e[62], e[62:42]};
        return t;
    endfunction

    function automatic logic [ENTRY_W-1:0] pack_trip(input hcr_trip_t t);
        return {t.c[20:0], t.b[20:0], t.a[20:0]};
    endfunction

endpackage

>>> sv/hcr_ram.sv
module hcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/hcr_front.sv
module hcr_front #(
    parameter int MAX_WIDTH = hcr_pkg::MAX_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcr_pkg::hcr_cfg_t   cfg,
    input  logic                clear_busy,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic                frame_start,
    output hcr_pkg::hcr_item_t  item,
    output logic                item_avail,
    input  logic                item_take
);

    localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);

    logic [hcr_pkg::COL_W-1:0] col_reg, col_next;
    logic [hcr_pkg::ROW_W-1:0] row_reg, row_next;
    hcr_pkg::hcr_item_t        q_reg [2];
    logic                      wp_reg, rp_reg;
    logic [1:0]                cnt_reg, cnt_next;
    logic [12:0]               w_eff, col_inc;
    logic [10:0]               h_eff, row_inc;
    logic [15:0]               grey_sum;
    logic [hcr_pkg::COL_W-1:0] col_use;
    logic [hcr_pkg::ROW_W-1:0] row_use;
    hcr_pkg::hcr_item_t        push_item;
    logic                      push;

    // clamp geometry
    always_comb
    begin
        if (cfg.image_width < 11'd8)
            w_eff = 13'd8;
        else if (13'(cfg.image_width) > MAX_W)
            w_eff = MAX_W;
        else
            w_eff = 13'(cfg.image_width);
        if (cfg.image_height < 11'd8)
            h_eff = 11'd8;
        else if (cfg.image_height > 11'd1024)
            h_eff = 11'd1024;
        else
            h_eff = cfg.image_height;
    end

    // grey conversion and raster position
    always_comb
    begin
        grey_sum = 16'(16'd54 * red) + 16'(16'd183 * green) + 16'(16'd18 * blue);
        col_use  = frame_start ? '0 : col_reg;
        row_use  = frame_start ? '0 : row_reg;
        col_inc  = 13'(col_use) + 13'd1;
        row_inc  = 11'(row_use) + 11'd1;
        push_item.grey = grey_sum[15:8];
        push_item.row  = row_use;
        push_item.col  = col_use;
        col_next = col_reg;
        row_next = row_reg;
        push     = pixel_valid && pixel_ready;
        if (push)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[9:0];
            end
            else
            begin
                col_next = col_inc[hcr_pkg::COL_W-1:0];
                row_next = row_use;
            end
        end
    end

    // two-entry queue towards the back end
    assign pixel_ready = (cnt_reg != 2'd2) && !clear_busy;
    assign item_avail  = (cnt_reg != 2'd0);
    assign item        = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !item_take)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && item_take)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= !wp_reg;
            if (item_take)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= push_item;
    end

endmodule

>>> sv/hcr_back.sv
module hcr_back #(
    parameter int MAX_WIDTH     = hcr_pkg::MAX_WIDTH_DEF,
    parameter int SMOOTH_RADIUS = hcr_pkg::SMOOTH_RADIUS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcr_pkg::hcr_cfg_t   cfg,
    output logic                clear_busy,
    input  hcr_pkg::hcr_item_t  item,
    input  logic                item_avail,
    output logic                item_take,
    output logic                result_valid,
    input  logic                result_ready,
    output logic signed [43:0]  response,
    output logic                is_corner,
    output logic [9:0]          pixel_row,
    output logic [9:0]          pixel_col,
    output logic                valid_res
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int PW   = hcr_pkg::ENTRY_W * hcr_pkg::PROD_LINES;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);
    localparam logic [2:0] TAP_TOP   = 3'(3 + SMOOTH_RADIUS);
    localparam logic [2:0] LAST_STEP = 3'(2 * SMOOTH_RADIUS);
    localparam logic [2:0] D_SMOOTH  = 3'(1 + SMOOTH_RADIUS);
    localparam logic signed [45:0] RESP_MAX = 46'sd8796093022207;
    localparam logic signed [45:0] RESP_MIN = -46'sd8796093022208;

    hcr_pkg::hcr_state_t state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    hcr_pkg::hcr_item_t  cur_reg, cur_next;
    logic [7:0]          win_reg [3][3];
    logic [7:0]          win_next [3][3];
    logic [hcr_pkg::ENTRY_W-1:0] prow_reg [hcr_pkg::PROD_LINES];
    logic [hcr_pkg::ENTRY_W-1:0] prow_next [hcr_pkg::PROD_LINES];
    logic [hcr_pkg::ENTRY_W-1:0] sw_reg [hcr_pkg::WIN_TAPS];
    logic [hcr_pkg::ENTRY_W-1:0] sw_next [hcr_pkg::WIN_TAPS];
    logic [20:0]         xx_reg, xx_next, yy_reg, yy_next, xy_reg, xy_next;
    logic signed [31:0]  acca_reg, acca_next, accb_reg, accb_next, accc_reg, accc_next;
    logic [2:0]          step_reg, step_next;
    logic signed [21:0]  sa_reg, sa_next, sb_reg, sb_next, sc_reg, sc_next;
    logic signed [43:0]  p1_reg, p1_next, p2_reg, p2_next;
    logic [43:0]         t2_reg, t2_next;
    logic signed [44:0]  det_reg, det_next;
    logic [42:0]         kt_reg, kt_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [43:0]  resp_reg, resp_next;
    logic                corner_reg, corner_next, vres_reg, vres_next;
    logic [9:0]          prow_o_reg, prow_o_next, pcol_o_reg, pcol_o_next;

    // memory ports
    logic [AW-1:0]       raddr, waddr;
    logic                g_we, p_we;
    logic [15:0]         g_wdata, g_rdata;
    logic [PW-1:0]       p_wdata, p_rdata;

    // datapath helpers
    logic [9:0]          top_s, bot_s, rgt_s, lft_s;
    logic signed [10:0]  ix, iy;
    logic signed [21:0]  sq_x, sq_y, sq_xy;
    hcr_pkg::hcr_trip_t  new_t, term_t, v_t;
    logic [2:0]          step_m1;
    logic signed [7:0]   tap_s;
    logic signed [31:0]  fa, fb, fc;
    logic [22:0]         trace;
    logic [50:0]         kprod;
    logic signed [45:0]  resp_w, resp_sat;
    logic [2:0]          d_val;
    logic [3:0]          d2_val;
    logic                valid_w, pos_ok;

    hcr_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_grey_lines (
        .clk   (clk),
        .we    (g_we),
        .waddr (waddr),
        .wdata (g_wdata),
        .raddr (raddr),
        .rdata (g_rdata)
    );

    hcr_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_prod_lines (
        .clk   (clk),
        .we    (p_we),
        .waddr (waddr),
        .wdata (p_wdata),
        .raddr (raddr),
        .rdata (p_rdata)
    );

    assign clear_busy   = (state_reg == hcr_pkg::B_CLEAR);
    assign result_valid = out_valid_reg;
    assign response     = resp_reg;
    assign is_corner    = corner_reg;
    assign pixel_row    = prow_o_reg;
    assign pixel_col    = pcol_o_reg;
    assign valid_res    = vres_reg;

    // sobel gradients and products from the window
    always_comb
    begin
        top_s = 10'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0} + 10'(win_reg[0][2]);
        bot_s = 10'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0} + 10'(win_reg[2][2]);
        rgt_s = 10'(win_reg[0][2]) + {1'b0, win_reg[1][2], 1'b0} + 10'(win_reg[2][2]);
        lft_s = 10'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0} + 10'(win_reg[2][0]);
        ix    = $signed({1'b0, top_s}) - $signed({1'b0, bot_s});
        iy    = $signed({1'b0, rgt_s}) - $signed({1'b0, lft_s});
        sq_x  = ix * ix;
        sq_y  = iy * iy;
        sq_xy = ix * iy;
    end

    // tap selection for both gaussian passes
    always_comb
    begin
        new_t.a = {1'b0, xx_reg};
        new_t.b = {1'b0, yy_reg};
        new_t.c = {xy_reg[20], xy_reg};
        step_m1 = (step_reg == 3'd0) ? 3'd0 : step_reg - 3'd1;
        tap_s   = $signed({1'b0, hcr_pkg::gauss_tap(TAP_TOP - step_reg)});
        if (state_reg == hcr_pkg::B_HACC)
            term_t = hcr_pkg::unpack_trip(sw_reg[step_reg]);
        else if (step_reg == 3'd0)
            term_t = new_t;
        else
            term_t = hcr_pkg::unpack_trip(prow_reg[step_m1]);
        fa = acca_reg >>> 8;
        fb = accb_reg >>> 8;
        fc = accc_reg >>> 8;
        v_t.a = fa[21:0];
        v_t.b = fb[21:0];
        v_t.c = fc[21:0];
    end

    // response, saturation and position
    always_comb
    begin
        trace    = 23'(sa_reg) + 23'(sb_reg);
        kprod    = 51'(cfg.k_weight) * 51'(t2_reg);
        resp_w   = 46'(det_reg) - $signed({3'b000, kt_reg});
        if (resp_w > RESP_MAX)
            resp_sat = RESP_MAX;
        else if (resp_w < RESP_MIN)
            resp_sat = RESP_MIN;
        else
            resp_sat = resp_w;
        d_val   = cfg.smooth_enable ? D_SMOOTH : 3'd1;
        d2_val  = {d_val, 1'b0};
        valid_w = (cur_reg.row >= 10'(d2_val)) && (cur_reg.col >= 12'(d2_val));
        pos_ok  = (cur_reg.row >= 10'(d_val)) && (cur_reg.col >= 12'(d_val));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        win_next       = win_reg;
        prow_next      = prow_reg;
        sw_next        = sw_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        acca_next      = acca_reg;
        accb_next      = accb_reg;
        accc_next      = accc_reg;
        step_next      = step_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        sc_next        = sc_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        t2_next        = t2_reg;
        det_next       = det_reg;
        kt_next        = kt_reg;
        resp_next      = resp_reg;
        corner_next    = corner_reg;
        vres_next      = vres_reg;
        prow_o_next    = prow_o_reg;
        pcol_o_next    = pcol_o_reg;
        out_valid_next = out_valid_reg && !result_ready;
        item_take      = 1'b0;
        raddr          = item.col[AW-1:0];
        waddr          = cur_reg.col[AW-1:0];
        g_we           = 1'b0;
        p_we           = 1'b0;
        g_wdata        = {cur_reg.grey, g_rdata[15:8]};
        for (int j = 0; j < hcr_pkg::PROD_LINES; j++)
        begin
            if (j == 0)
                p_wdata[j*hcr_pkg::ENTRY_W +: hcr_pkg::ENTRY_W] = hcr_pkg::pack_trip(new_t);
            else
                p_wdata[j*hcr_pkg::ENTRY_W +: hcr_pkg::ENTRY_W] = prow_reg[j-1];
        end
        case (state_reg)
            // zero the line buffers after reset
            hcr_pkg::B_CLEAR:
            begin
                waddr   = clr_reg;
                g_we    = 1'b1;
                p_we    = 1'b1;
                g_wdata = '0;
                p_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                    state_next = hcr_pkg::B_IDLE;
            end
            // take an item and read its column
            hcr_pkg::B_IDLE:
            begin
                if (item_avail)
                begin
                    item_take  = 1'b1;
                    cur_next   = item;
                    state_next = hcr_pkg::B_WIN;
                end
            end
            // shift the grey window, update grey lines
            hcr_pkg::B_WIN:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_next[r][0] = win_reg[r][1];
                    win_next[r][1] = win_reg[r][2];
                end
                win_next[0][2] = g_rdata[7:0];
                win_next[1][2] = g_rdata[15:8];
                win_next[2][2] = cur_reg.grey;
                g_we = 1'b1;
                for (int j = 0; j < hcr_pkg::PROD_LINES; j++)
                    prow_next[j] = p_rdata[j*hcr_pkg::ENTRY_W +: hcr_pkg::ENTRY_W];
                state_next = hcr_pkg::B_PROD;
            end
            hcr_pkg::B_PROD:
            begin
                xx_next    = sq_x[20:0];
                yy_next    = sq_y[20:0];
                xy_next    = sq_xy[20:0];
                acca_next  = '0;
                accb_next  = '0;
                accc_next  = '0;
                step_next  = 3'd0;
                state_next = hcr_pkg::B_VACC;
            end
            // vertical pass, one line per cycle
            hcr_pkg::B_VACC:
            begin
                if (step_reg == 3'd0)
                    p_we = 1'b1;
                acca_next = acca_reg + 32'(tap_s * term_t.a);
                accb_next = accb_reg + 32'(tap_s * term_t.b);
                accc_next = accc_reg + 32'(tap_s * term_t.c);
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                    state_next = hcr_pkg::B_VFLR;
            end
            hcr_pkg::B_VFLR:
            begin
                for (int i = hcr_pkg::WIN_TAPS - 1; i > 0; i--)
                    sw_next[i] = sw_reg[i-1];
                sw_next[0] = hcr_pkg::pack_trip(v_t);
                acca_next  = '0;
                accb_next  = '0;
                accc_next  = '0;
                step_next  = 3'd0;
                state_next = hcr_pkg::B_HACC;
            end
            // horizontal pass, one column per cycle
            hcr_pkg::B_HACC:
            begin
                acca_next = acca_reg + 32'(tap_s * term_t.a);
                accb_next = accb_reg + 32'(tap_s * term_t.b);
                accc_next = accc_reg + 32'(tap_s * term_t.c);
                step_next = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                    state_next = hcr_pkg::B_HFLR;
            end
            hcr_pkg::B_HFLR:
            begin
                if (cfg.smooth_enable)
                begin
                    sa_next = v_t.a;
                    sb_next = v_t.b;
                    sc_next = v_t.c;
                end
                else
                begin
                    sa_next = new_t.a;
                    sb_next = new_t.b;
                    sc_next = new_t.c;
                end
                state_next = hcr_pkg::B_MUL;
            end
            hcr_pkg::B_MUL:
            begin
                p1_next    = sa_reg * sb_reg;
                p2_next    = sc_reg * sc_reg;
                t2_next    = 44'(trace[21:0]) * 44'(trace[21:0]);
                state_next = hcr_pkg::B_KMUL;
            end
            hcr_pkg::B_KMUL:
            begin
                det_next   = 45'(p1_reg) - 45'(p2_reg);
                kt_next    = kprod[50:8];
                state_next = hcr_pkg::B_RESP;
            end
            // load the output register once it is free
            hcr_pkg::B_RESP:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    vres_next      = valid_w;
                    resp_next      = valid_w ? resp_sat[43:0] : '0;
                    corner_next    = valid_w &&
                                     (resp_sat > $signed({3'b000, cfg.corner_threshold}));
                    prow_o_next    = pos_ok ? cur_reg.row - 10'(d_val) : '0;
                    pcol_o_next    = pos_ok ? 10'(cur_reg.col - 12'(d_val)) : '0;
                    state_next     = hcr_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = hcr_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcr_pkg::B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
            for (int i = 0; i < hcr_pkg::WIN_TAPS; i++)
                sw_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
            sw_reg        <= sw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prow_reg   <= prow_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        xy_reg     <= xy_next;
        acca_reg   <= acca_next;
        accb_reg   <= accb_next;
        accc_reg   <= accc_next;
        step_reg   <= step_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        sc_reg     <= sc_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        t2_reg     <= t2_next;
        det_reg    <= det_next;
        kt_reg     <= kt_next;
        resp_reg   <= resp_next;
        corner_reg <= corner_next;
        vres_reg   <= vres_next;
        prow_o_reg <= prow_o_next;
        pcol_o_reg <= pcol_o_next;
    end

endmodule

>>> sv/harris_corner_response_core.sv
// sequencer: after taking a pixel the back end runs the window, product and gaussian pass
// states, one tap per cycle, then the multiplies, before it loads the result register
// pixel flow: the back end takes a new pixel only after loading the last result; the queue in
// front holds two pixels
// reset: config returns to defaults, then the line buffers are cleared, during which no
// pixel is accepted
module harris_corner_response_core #(
    parameter int MAX_WIDTH     = hcr_pkg::MAX_WIDTH_DEF,
    parameter int SMOOTH_RADIUS = hcr_pkg::SMOOTH_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [7:0]                        red,
    input  logic [7:0]                        green,
    input  logic [7:0]                        blue,
    input  logic                              frame_start,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [43:0]                response,
    output logic                              is_corner,
    output logic [9:0]                        pixel_row,
    output logic [9:0]                        pixel_col,
    output logic                              valid_res
);

    hcr_pkg::hcr_cfg_t  cfg_reg;
    hcr_pkg::hcr_item_t item;
    logic               item_avail, item_take, clear_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= hcr_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height     <= hcr_pkg::IMAGE_HEIGHT_RST;
            cfg_reg.k_weight         <= hcr_pkg::K_WEIGHT_RST;
            cfg_reg.corner_threshold <= hcr_pkg::CORNER_THRESHOLD_RST;
            cfg_reg.smooth_enable    <= hcr_pkg::SMOOTH_ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcr_pkg::CFG_IMAGE_WIDTH:      cfg_reg.image_width      <= cfg_data[10:0];
                hcr_pkg::CFG_IMAGE_HEIGHT:     cfg_reg.image_height     <= cfg_data[10:0];
                hcr_pkg::CFG_K_WEIGHT:         cfg_reg.k_weight         <= cfg_data[6:0];
                hcr_pkg::CFG_CORNER_THRESHOLD: cfg_reg.corner_threshold <= cfg_data;
                hcr_pkg::CFG_SMOOTH_ENABLE:    cfg_reg.smooth_enable    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    hcr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear_busy  (clear_busy),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_start (frame_start),
        .item        (item),
        .item_avail  (item_avail),
        .item_take   (item_take)
    );

    hcr_back #(.MAX_WIDTH(MAX_WIDTH), .SMOOTH_RADIUS(SMOOTH_RADIUS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .clear_busy   (clear_busy),
        .item         (item),
        .item_avail   (item_avail),
        .item_take    (item_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .response     (response),
        .is_corner    (is_corner),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .valid_res    (valid_res)
    );

endmodule
